// ===== rtl/core/vrc_pkg.sv =====
// Package for the volume render compositor.
// Holds field widths, defaults and the types shared by the front, queue and back.
// Depends on nothing.
`default_nettype none

package vrc_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int ALPHA_W           = 17;
  localparam int COLOR_W           = 16;
  localparam int DEPTH_W           = 32;
  localparam int CSUM_W            = 17;
  localparam int WEIGHT_W          = 17;
  localparam int OPACITY_W         = 17;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } vrc_sample_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vrc_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/vrc_stream_if.sv =====
// Valid/ready channel interfaces for the compositor's sample input and result output.
// Depends on vrc_pkg for the field widths.
`default_nettype none

interface vrc_in_if;
  import vrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha;
  logic [COLOR_W-1:0] red_in;
  logic [COLOR_W-1:0] green_in;
  logic [COLOR_W-1:0] blue_in;
  logic [DEPTH_W-1:0] sample_depth;
  logic               last_sample;

  modport source (output valid, alpha, red_in, green_in, blue_in, sample_depth,
                  last_sample, input ready);
  modport sink (input valid, alpha, red_in, green_in, blue_in, sample_depth,
                last_sample, output ready);
endinterface

interface vrc_out_if;
  import vrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WEIGHT_W-1:0]  weight;
  logic [COLOR_W-1:0]   red_out;
  logic [COLOR_W-1:0]   green_out;
  logic [COLOR_W-1:0]   blue_out;
  logic [DEPTH_W-1:0]   depth_out;
  logic [OPACITY_W-1:0] opacity_out;
  logic                 ray_done;

  modport source (output valid, weight, red_out, green_out, blue_out, depth_out,
                  opacity_out, ray_done, input ready);
  modport sink (input valid, weight, red_out, green_out, blue_out, depth_out,
                opacity_out, ray_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vrc_front.sv =====
// Front end of the compositor: accepts samples, computes each weight and keeps transmittance.
// Depends on vrc_pkg and vrc_in_if; feeds vrc_queue.
`default_nettype none

module vrc_front #(
  parameter int FRACTION_BITS = vrc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  vrc_in_if.sink                     in_chan,
  input  wire vrc_pkg::vrc_qstat_t   qstat,
  output logic                       push,
  output vrc_pkg::vrc_sample_t       push_smp,
  output logic [FRACTION_BITS:0]     push_w
);
  import vrc_pkg::*;

  localparam int TW = FRACTION_BITS + 1;
  localparam int AW = (TW > ALPHA_W) ? TW : ALPHA_W;
  localparam int MW = 2 * TW;
  localparam logic [TW-1:0] ONE  = TW'(1) << FRACTION_BITS;
  localparam logic [TW-1:0] HALF = TW'(1) << (FRACTION_BITS - 1);

  typedef enum logic {S_IDLE, S_PUSH} state_t;

  state_t          state_r;
  logic [TW-1:0]   trans_r;
  logic [TW-1:0]   trans_nxt;
  logic [MW-1:0]   prod_r;
  logic [MW-1:0]   prod_nxt;
  logic [MW-1:0]   rnd;
  vrc_sample_t     smp_r;
  logic [AW-1:0]   alpha_ext;
  logic [TW-1:0]   alpha_c;
  logic [TW-1:0]   w;
  logic            accept;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  assign alpha_ext = AW'(in_chan.alpha);
  assign alpha_c   = (alpha_ext > AW'(ONE)) ? ONE : alpha_ext[TW-1:0];
  assign prod_nxt  = MW'(alpha_c) * MW'(trans_r);

  assign rnd       = prod_r + MW'(HALF);
  assign w         = rnd[FRACTION_BITS+TW-1:FRACTION_BITS];
  assign trans_nxt = smp_r.last ? ONE : (trans_r - w);

  assign push     = (state_r == S_PUSH) && !qstat.full;
  assign push_smp = smp_r;
  assign push_w   = w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      trans_r <= ONE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push) begin
            trans_r <= trans_nxt;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r      <= prod_nxt;
      smp_r.red   <= in_chan.red_in;
      smp_r.green <= in_chan.green_in;
      smp_r.blue  <= in_chan.blue_in;
      smp_r.depth <= in_chan.sample_depth;
      smp_r.last  <= in_chan.last_sample;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrc_queue.sv =====
// Two-entry queue between the compositor's front and back ends.
// Depends on vrc_pkg for the status struct.
`default_nettype none

module vrc_queue #(
  parameter int DW = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire logic [DW-1:0]       push_data,
  input  wire logic                pop,
  output logic [DW-1:0]            pop_data,
  output vrc_pkg::vrc_qstat_t      qstat
);
  import vrc_pkg::*;

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;

  assign qstat.full  = (count_r == 2'd2);
  assign qstat.empty = (count_r == 2'd0);
  assign pop_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrc_back.sv =====
// Back end of the compositor: weights colour and depth, accumulates, adds background.
// Depends on vrc_pkg and vrc_out_if; drains vrc_queue and holds the result register.
`default_nettype none

module vrc_back #(
  parameter int FRACTION_BITS = vrc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata,
  input  wire vrc_pkg::vrc_qstat_t   qstat,
  input  wire vrc_pkg::vrc_sample_t  pop_smp,
  input  wire logic [FRACTION_BITS:0] pop_w,
  output logic                       pop,
  vrc_out_if.source                  out_chan
);
  import vrc_pkg::*;

  localparam int TW  = FRACTION_BITS + 1;
  localparam int CW  = (TW > CSUM_W) ? TW : CSUM_W;
  localparam int PW  = TW + COLOR_W;
  localparam int DPW = TW + DEPTH_W;
  localparam logic [TW-1:0] ONE  = TW'(1) << FRACTION_BITS;
  localparam logic [TW-1:0] HALF = TW'(1) << (FRACTION_BITS - 1);
  localparam logic [CSUM_W-1:0]   MAX_CSUM = '1;
  localparam logic [COLOR_W-1:0]  MAX_COL  = '1;
  localparam logic [DEPTH_W-1:0]  MAX_DEP  = '1;
  localparam logic [WEIGHT_W-1:0] MAX_W17  = '1;

  typedef enum logic {B_IDLE, B_ACC} state_t;

  state_t             state_r;
  logic               wb_r;
  logic [CSUM_W-1:0]  sum_red_r, sum_green_r, sum_blue_r;
  logic [CSUM_W-1:0]  sum_red_nxt, sum_green_nxt, sum_blue_nxt;
  logic [DEPTH_W-1:0] sum_depth_r, sum_depth_nxt;
  logic [TW-1:0]      sum_op_r, sum_op_nxt;
  logic [PW-1:0]      pr_r, pg_r, pb_r;
  logic [DPW-1:0]     pd_r;
  logic [TW-1:0]      w_r;
  logic               last_r;
  logic               load;
  logic [DPW-1:0]     rd;
  logic [DEPTH_W:0]   qd;
  logic [DEPTH_W+1:0] sd;
  logic [TW:0]        so;
  logic [TW-1:0]      bg;
  logic               bg_en;
  logic [CW-1:0]      w_ext, op_ext;

  logic                 ov_r;
  logic [WEIGHT_W-1:0]  wt_r;
  logic [COLOR_W-1:0]   ro_r, go_r, bo_r;
  logic [DEPTH_W-1:0]   do_r;
  logic [OPACITY_W-1:0] oo_r;
  logic                 done_r;

  function automatic logic [CSUM_W-1:0] acc_col(input logic [CSUM_W-1:0] sum,
                                                input logic [PW-1:0] prod);
    logic [PW-1:0]     rnd;
    logic [CSUM_W:0]   tot;
    rnd = prod + PW'(HALF);
    tot = {1'b0, sum} + {1'b0, rnd[PW-1:FRACTION_BITS]};
    return tot[CSUM_W] ? MAX_CSUM : tot[CSUM_W-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] col_out(input logic [CSUM_W-1:0] sum,
                                                 input logic en,
                                                 input logic [TW-1:0] bgv);
    logic [CW:0] tot;
    tot = (CW+1)'(sum) + (en ? (CW+1)'(bgv) : '0);
    return (tot > (CW+1)'(MAX_COL)) ? MAX_COL : tot[COLOR_W-1:0];
  endfunction

  assign pop  = (state_r == B_IDLE) && !qstat.empty;
  assign load = (state_r == B_ACC) && (!ov_r || out_chan.ready);

  always_comb begin
    sum_red_nxt   = acc_col(sum_red_r, pr_r);
    sum_green_nxt = acc_col(sum_green_r, pg_r);
    sum_blue_nxt  = acc_col(sum_blue_r, pb_r);
    rd            = pd_r + DPW'(HALF);
    qd            = rd[DPW-1:FRACTION_BITS];
    sd            = {2'b00, sum_depth_r} + {1'b0, qd};
    sum_depth_nxt = (sd[DEPTH_W+1:DEPTH_W] != 2'b00) ? MAX_DEP : sd[DEPTH_W-1:0];
    so            = {1'b0, sum_op_r} + {1'b0, w_r};
    sum_op_nxt    = (so > {1'b0, ONE}) ? ONE : so[TW-1:0];
    bg            = ONE - sum_op_nxt;
    bg_en         = last_r && wb_r;
    w_ext         = CW'(w_r);
    op_ext        = CW'(sum_op_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wb_r        <= 1'b0;
      ov_r        <= 1'b0;
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
      sum_depth_r <= '0;
      sum_op_r    <= '0;
    end else begin
      if (cfg_we) begin
        wb_r <= cfg_wdata;
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop) begin
            state_r <= B_ACC;
          end
        end
        B_ACC: begin
          if (load) begin
            state_r     <= B_IDLE;
            sum_red_r   <= last_r ? '0 : sum_red_nxt;
            sum_green_r <= last_r ? '0 : sum_green_nxt;
            sum_blue_r  <= last_r ? '0 : sum_blue_nxt;
            sum_depth_r <= last_r ? '0 : sum_depth_nxt;
            sum_op_r    <= last_r ? '0 : sum_op_nxt;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pr_r   <= PW'(pop_w) * PW'(pop_smp.red);
      pg_r   <= PW'(pop_w) * PW'(pop_smp.green);
      pb_r   <= PW'(pop_w) * PW'(pop_smp.blue);
      pd_r   <= DPW'(pop_w) * DPW'(pop_smp.depth);
      w_r    <= pop_w;
      last_r <= pop_smp.last;
    end
    if (load) begin
      wt_r   <= (w_ext > CW'(MAX_W17)) ? MAX_W17 : w_ext[WEIGHT_W-1:0];
      ro_r   <= col_out(sum_red_nxt, bg_en, bg);
      go_r   <= col_out(sum_green_nxt, bg_en, bg);
      bo_r   <= col_out(sum_blue_nxt, bg_en, bg);
      do_r   <= sum_depth_nxt;
      oo_r   <= (op_ext > CW'(MAX_W17)) ? MAX_W17 : op_ext[OPACITY_W-1:0];
      done_r <= last_r;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.weight      = wt_r;
  assign out_chan.red_out     = ro_r;
  assign out_chan.green_out   = go_r;
  assign out_chan.blue_out    = bo_r;
  assign out_chan.depth_out   = do_r;
  assign out_chan.opacity_out = oo_r;
  assign out_chan.ray_done    = done_r;

endmodule

`default_nettype wire

// ===== rtl/core/volume_render_compositor_unit.sv =====
// Top level of the volume render compositor: front end, queue and back end.
// Depends on vrc_pkg, vrc_stream_if, vrc_front, vrc_queue and vrc_back.
//
// Front-to-back alpha compositing of a ray, one result transaction per sample
// transaction. The front end takes no new sample until it has pushed the last
// one: it multiplies alpha by the running transmittance into prod_r, then rounds
// the weight and updates transmittance as it pushes, which waits while the queue is full.
// The back end registers the weighted colour and depth products on a pop, then
// accumulates them into the output register when that register is free. A
// two-entry queue and the output register let either side stall alone. The white
// background bit is written through cfg_we and cfg_wdata; the user must do so
// only while idle, as the block itself does not enforce it.
`default_nettype none

module volume_render_compositor_unit #(
  parameter int FRACTION_BITS = vrc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vrc_in_if.sink     in_chan,
  vrc_out_if.source  out_chan,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);
  import vrc_pkg::*;

  localparam int TW = FRACTION_BITS + 1;
  localparam int DW = $bits(vrc_sample_t) + TW;

  logic              push;
  logic              pop;
  vrc_sample_t       push_smp;
  vrc_sample_t       pop_smp;
  logic [TW-1:0]     push_w;
  logic [TW-1:0]     pop_w;
  logic [DW-1:0]     pop_data;
  vrc_qstat_t        qstat;

  vrc_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .qstat    (qstat),
    .push     (push),
    .push_smp (push_smp),
    .push_w   (push_w)
  );

  vrc_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_smp, push_w}),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  assign pop_smp = pop_data[DW-1:TW];
  assign pop_w   = pop_data[TW-1:0];

  vrc_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .pop_smp   (pop_smp),
    .pop_w     (pop_w),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vrc_checker.sv =====
// Port-level checker for the volume render compositor, bound to the top level.
// Depends on vrc_pkg for the field widths.
`default_nettype none

module vrc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [vrc_pkg::WEIGHT_W-1:0]   weight,
  input wire logic [vrc_pkg::OPACITY_W-1:0]  opacity_out,
  input wire logic                           ray_done
);
  import vrc_pkg::*;

  logic                 ray_start_r;
  logic [OPACITY_W-1:0] prev_op_r;
  logic                 out_acc;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_start_r <= 1'b1;
      prev_op_r   <= '0;
    end else if (out_acc) begin
      ray_start_r <= ray_done;
      prev_op_r   <= opacity_out;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result transaction dropped before it was taken.");

  a_weight_le_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> weight <= opacity_out)
    else $error("Sample weight exceeds accumulated opacity.");

  a_ray_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && ray_start_r |-> opacity_out == weight)
    else $error("First sample of a ray did not start from cleared opacity.");

  a_op_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !ray_start_r |-> opacity_out >= prev_op_r)
    else $error("Accumulated opacity decreased within a ray.");

endmodule

bind volume_render_compositor_unit vrc_checker u_vrc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .weight      (out_chan.weight),
  .opacity_out (out_chan.opacity_out),
  .ray_done    (out_chan.ray_done)
);

`default_nettype wire
